/* hdl/bgr_pfc_pkg.sv */
// Shared types, format codes, coefficients and arithmetic helpers for the
// BGR pixel-pair format converter. No dependencies.
package bgr_pfc_pkg;

    // Output format codes; code three falls back to RGB24
    localparam logic [1:0] FMT_RGB24 = 2'd0;
    localparam logic [1:0] FMT_YUY2  = 2'd1;
    localparam logic [1:0] FMT_RGB32 = 2'd2;

    localparam logic [3:0] COUNT_YUY2  = 4'd4;
    localparam logic [3:0] COUNT_RGB24 = 4'd6;
    localparam logic [3:0] COUNT_RGB32 = 4'd8;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam int SUM_W = 18;
    localparam int BYTE_OFS_W = 11;

    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [BYTE_OFS_W-1:0] ofs_t;

    // BT.601 integer coefficients
    localparam sum_t CY_R = 18'sd66;
    localparam sum_t CY_G = 18'sd129;
    localparam sum_t CY_B = 18'sd25;
    localparam sum_t CU_R = -18'sd38;
    localparam sum_t CU_G = -18'sd74;
    localparam sum_t CU_B = 18'sd112;
    localparam sum_t CV_R = 18'sd112;
    localparam sum_t CV_G = -18'sd94;
    localparam sum_t CV_B = -18'sd18;
    localparam sum_t ROUND_HALF = 18'sd128;

    localparam ofs_t Y_OFFSET = 11'sd16;
    localparam ofs_t C_OFFSET = 11'sd128;

    // Six bytes of one pixel pair
    typedef struct packed {
        logic [7:0] r1;
        logic [7:0] g1;
        logic [7:0] b1;
        logic [7:0] r0;
        logic [7:0] g0;
        logic [7:0] b0;
    } pair_t;

    // Control that travels with each item
    typedef struct packed {
        logic [1:0] fmt;
        logic       last;
    } ctrl_t;

    typedef struct packed {
        sum_t y0;
        sum_t u;
        sum_t y1;
        sum_t v;
    } sums_t;

    function automatic sum_t widen(input logic [7:0] x);
        return $signed({{(SUM_W-8){1'b0}}, x});
    endfunction

    function automatic sum_t dot3(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input sum_t kr,
                                  input sum_t kg, input sum_t kb);
        return widen(r) * kr + widen(g) * kg + widen(b) * kb + ROUND_HALF;
    endfunction

    // Floor shift, add offset, clamp to a byte
    function automatic logic [7:0] scale_clamp(input sum_t s, input ofs_t ofs);
        sum_t sh;
        ofs_t val;
        sh  = s >>> 8;
        val = sh[BYTE_OFS_W-1:0] + ofs;
        if (val < 0)
            return 8'd0;
        else if (val > 11'sd255)
            return 8'hFF;
        else
            return val[7:0];
    endfunction

endpackage

/* hdl/bgr_pixel_pair_format_converter.sv */
// Top level of the BGR pixel-pair format converter: three-stage pipeline
// with per-stage valid bits. Depends on bgr_pfc_pkg and bgr_pfc_pack.
//
//  channel | direction | ports                                  | content
//  --------+-----------+----------------------------------------+-----------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tlast      | one BGR pixel pair
//  m_      | out       | m_tvalid m_tready m_tdata m_tlast      | packed word + count
//  cfg_    | in        | cfg_valid cfg_ready cfg_data           | output format
//
// One pair per clock sustained while m_tready stays high; a pair passes
// through the average, multiply-add and clamp-and-pack registers in that
// order before m_tvalid rises with its result.
// aresetn is synchronous, active low; it empties the pipeline and sets RGB24.
// A stage advances when the stage after it is empty or moving, so a stall on
// m_tready fills the bubbles before s_tready drops. cfg_ready is always high.
module bgr_pixel_pair_format_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // b0, g0, r0, b1, g1, r1 (bits 7:0 up)
    input  logic        s_tlast,   // frame_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // packed_bytes[63:0], byte_count[67:64], zero
    output logic        m_tlast,   // frame_last_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data   // output_format
);
    import bgr_pfc_pkg::*;

    logic [1:0] fmt_reg;

    logic  v1_reg, v2_reg, v3_reg;
    logic  adv1, adv2, adv3;
    pair_t pix1_reg, pix2_reg;
    ctrl_t ctrl1_reg, ctrl2_reg;
    logic [7:0] rc_reg, gc_reg, bc_reg;
    sums_t sums2_reg;
    logic [63:0] out_bytes_reg;
    logic [3:0]  out_count_reg;
    logic        out_last_reg;

    pair_t in_pix;
    logic [8:0] r_sum, g_sum, b_sum;
    logic [63:0] pack_bytes;
    logic [3:0]  pack_count;

    assign in_pix = s_tdata;
    assign r_sum  = {1'b0, in_pix.r0} + {1'b0, in_pix.r1};
    assign g_sum  = {1'b0, in_pix.g0} + {1'b0, in_pix.g1};
    assign b_sum  = {1'b0, in_pix.b0} + {1'b0, in_pix.b1};

    // A stage loads when it is free or its contents move on
    assign adv3 = !v3_reg || m_tready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign s_tready  = adv1;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_RGB24;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end else begin
            if (cfg_valid)
                fmt_reg <= cfg_data;
            if (adv1)
                v1_reg <= s_tvalid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    // Stage 1: capture pair, floor-average the colors
    always_ff @(posedge aclk) begin
        if (adv1) begin
            pix1_reg       <= in_pix;
            ctrl1_reg.fmt  <= fmt_reg;
            ctrl1_reg.last <= s_tlast;
            rc_reg         <= r_sum[8:1];
            gc_reg         <= g_sum[8:1];
            bc_reg         <= b_sum[8:1];
        end
    end

    // Stage 2: weighted sums with rounding bias
    always_ff @(posedge aclk) begin
        if (adv2) begin
            pix2_reg     <= pix1_reg;
            ctrl2_reg    <= ctrl1_reg;
            sums2_reg.y0 <= dot3(pix1_reg.r0, pix1_reg.g0, pix1_reg.b0, CY_R, CY_G, CY_B);
            sums2_reg.y1 <= dot3(pix1_reg.r1, pix1_reg.g1, pix1_reg.b1, CY_R, CY_G, CY_B);
            sums2_reg.u  <= dot3(rc_reg, gc_reg, bc_reg, CU_R, CU_G, CU_B);
            sums2_reg.v  <= dot3(rc_reg, gc_reg, bc_reg, CV_R, CV_G, CV_B);
        end
    end

    bgr_pfc_pack u_pack (
        .sums         (sums2_reg),
        .pix          (pix2_reg),
        .ctrl         (ctrl2_reg),
        .packed_bytes (pack_bytes),
        .byte_count   (pack_count)
    );

    // Stage 3: output register, held while the transfer waits
    always_ff @(posedge aclk) begin
        if (adv3) begin
            out_bytes_reg <= pack_bytes;
            out_count_reg <= pack_count;
            out_last_reg  <= ctrl2_reg.last;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {4'd0, out_count_reg, out_bytes_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* hdl/bgr_pfc_pack.sv */
// Final stage logic: scale and clamp the YUV sums, build the output word
// and byte count for the selected format. Depends on bgr_pfc_pkg.
module bgr_pfc_pack (
    input  bgr_pfc_pkg::sums_t  sums,
    input  bgr_pfc_pkg::pair_t  pix,
    input  bgr_pfc_pkg::ctrl_t  ctrl,
    output logic [63:0]         packed_bytes,
    output logic [3:0]          byte_count
);
    import bgr_pfc_pkg::*;

    logic [7:0] y0_byte;
    logic [7:0] u_byte;
    logic [7:0] y1_byte;
    logic [7:0] v_byte;

    assign y0_byte = scale_clamp(sums.y0, Y_OFFSET);
    assign y1_byte = scale_clamp(sums.y1, Y_OFFSET);
    assign u_byte  = scale_clamp(sums.u, C_OFFSET);
    assign v_byte  = scale_clamp(sums.v, C_OFFSET);

    always_comb begin
        unique case (ctrl.fmt)
            FMT_YUY2: begin
                packed_bytes = {32'd0, v_byte, y1_byte, u_byte, y0_byte};
                byte_count   = COUNT_YUY2;
            end
            FMT_RGB32: begin
                packed_bytes = {ALPHA_OPAQUE, pix.r1, pix.g1, pix.b1,
                                ALPHA_OPAQUE, pix.r0, pix.g0, pix.b0};
                byte_count   = COUNT_RGB32;
            end
            default: begin
                packed_bytes = {16'd0, pix};
                byte_count   = COUNT_RGB24;
            end
        endcase
    end

endmodule

/* hdl/bgr_pfc_checker.sv */
// Port-level checks for the BGR pixel-pair format converter, attached to the
// top level by bind. Depends on bgr_pixel_pair_format_converter ports only.
module bgr_pfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled result transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_count_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[67:64] == 4'd4 || m_tdata[67:64] == 4'd6
                      || m_tdata[67:64] == 4'd8))
        else $error("illegal byte count");

    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[67:64] == 4'd4 |-> m_tdata[63:32] == 32'd0
                                               && m_tdata[71:68] == 4'd0)
        else $error("unused bytes not zero");

    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[67:64] == 4'd8 |-> m_tdata[31:24] == 8'hFF
                                               && m_tdata[63:56] == 8'hFF)
        else $error("alpha byte not opaque");

    a_luma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[67:64] == 4'd4 |->
            m_tdata[7:0] >= 8'd16 && m_tdata[7:0] <= 8'd235
            && m_tdata[23:16] >= 8'd16 && m_tdata[23:16] <= 8'd235)
        else $error("luma out of range");

endmodule

bind bgr_pixel_pair_format_converter bgr_pfc_checker u_checker (.*);

/* bench/bgr_pixel_pair_format_converter_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for bgr_pixel_pair_format_converter: streams BGR pixel pairs through
// every output format and compares each packed word with a local prediction.
// Depends on bgr_pfc_pkg and the converter RTL.
module bgr_pixel_pair_format_converter_tb;
    import bgr_pfc_pkg::*;

    // Undefined selector; the block treats it as RGB24
    localparam logic [1:0] FMT_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PAIRS_PER_PHASE = 55;

    typedef struct packed {
        pair_t pixels;
        logic  last;
    } pair_item_t;

    typedef struct packed {
        logic [63:0] packed_bytes;
        logic [3:0]  byte_count;
        logic        frame_last;
    } pixel_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = FMT_RGB24;

    pair_item_t  pairs_to_send[$];
    pixel_word_t expected_words[$];
    logic [1:0]  active_format = FMT_RGB24;
    logic        steady = 1'b0;
    int          mismatches = 0;
    int          cycles = 0;
    int          src_gap = 0;
    int          sink_gap = 0;

    pair_t corner_pairs[6] = '{
        48'h000000_000000,
        48'hFFFFFF_FFFFFF,
        48'h00FFFF_FF0000,   // red, then cyan
        48'hFFFF00_0000FF,   // blue, then yellow
        48'hFF00FF_00FF00,   // green, then magenta
        48'h55AA55_AA55AA
    };

    logic [1:0] phase_format[RANDOM_PHASES] = '{
        FMT_YUY2, FMT_RGB24, FMT_RGB32, FMT_RESERVED, FMT_YUY2,
        FMT_RGB32, FMT_YUY2, FMT_RGB24, FMT_YUY2, FMT_RESERVED
    };

    bgr_pixel_pair_format_converter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // b0, g0, r0, b1, g1, r1 (bits 7:0 up)
        .s_tlast  (s_tlast),    // frame_last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // packed_bytes[63:0], byte_count[67:64], zero pad
        .m_tlast  (m_tlast),    // frame_last_out
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)    // output_format
    );

    always #2 aclk = ~aclk;

    function automatic logic [7:0] sat_u8(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'hFF;
        return v[7:0];
    endfunction

    // Floor shift by 8 on signed int; offsets applied after the shift
    function automatic logic [7:0] luma_of(input int r, input int g, input int b);
        return sat_u8(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
    endfunction

    function automatic pixel_word_t convert_pair(input logic [1:0] fmt, input pair_t p,
                                                 input logic last);
        pixel_word_t w;
        int rc, gc, bc;
        logic [7:0] y0, y1, u, v;
        w.frame_last = last;
        if (fmt == FMT_YUY2) begin
            rc = (int'(p.r0) + int'(p.r1)) >>> 1;
            gc = (int'(p.g0) + int'(p.g1)) >>> 1;
            bc = (int'(p.b0) + int'(p.b1)) >>> 1;
            y0 = luma_of(int'(p.r0), int'(p.g0), int'(p.b0));
            y1 = luma_of(int'(p.r1), int'(p.g1), int'(p.b1));
            u  = sat_u8(((-38 * rc - 74 * gc + 112 * bc + 128) >>> 8) + 128);
            v  = sat_u8(((112 * rc - 94 * gc - 18 * bc + 128) >>> 8) + 128);
            w.packed_bytes = {32'd0, v, y1, u, y0};
            w.byte_count   = COUNT_YUY2;
        end else if (fmt == FMT_RGB32) begin
            w.packed_bytes = {ALPHA_OPAQUE, p.r1, p.g1, p.b1, ALPHA_OPAQUE, p.r0, p.g0, p.b0};
            w.byte_count   = COUNT_RGB32;
        end else begin
            w.packed_bytes = {16'd0, p.r1, p.g1, p.b1, p.r0, p.g0, p.b0};
            w.byte_count   = COUNT_RGB24;
        end
        return w;
    endfunction

    // Mostly short gaps, a few long ones; none while steady
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Bias toward the ends of the byte range to hit clamping and corner colors
    function automatic logic [7:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 8'h00;
        if (r < 4)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_pair(input pair_t p, input logic last);
        pair_item_t it;
        it.pixels = p;
        it.last   = last;
        pairs_to_send.push_back(it);
    endtask

    task automatic write_format(input logic [1:0] fmt);
        @(posedge aclk);
        cfg_data  <= fmt;
        cfg_valid <= 1'b1;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_format = fmt;
    endtask

    // Wait until every queued pair is transferred and every word has come back
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pairs_to_send.size() != 0 || s_tvalid || expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Source side: predict on each transfer, then present the next pair
    always @(posedge aclk) begin
        pair_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_words.push_back(convert_pair(active_format, s_tdata, s_tlast));
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pairs_to_send.size() != 0) begin
                    it = pairs_to_send.pop_front();
                    s_tdata  <= it.pixels;
                    s_tlast  <= it.last;
                    s_tvalid <= 1'b1;
                    src_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: check each transfer against the oldest prediction
    always @(posedge aclk) begin
        pixel_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word %h count %0d last %b", $time,
                             m_tdata[63:0], m_tdata[67:64], m_tlast);
                end else begin
                    want = expected_words.pop_front();
                    if (m_tdata[63:0] !== want.packed_bytes) begin
                        mismatches++;
                        $display("%0t: packed_bytes expected %h actual %h", $time,
                                 want.packed_bytes, m_tdata[63:0]);
                    end
                    if (m_tdata[67:64] !== want.byte_count) begin
                        mismatches++;
                        $display("%0t: byte_count expected %0d actual %0d", $time,
                                 want.byte_count, m_tdata[67:64]);
                    end
                    if (m_tlast !== want.frame_last) begin
                        mismatches++;
                        $display("%0t: frame_last expected %b actual %b", $time,
                                 want.frame_last, m_tlast);
                    end
                    if (m_tdata[71:68] !== 4'd0) begin
                        mismatches++;
                        $display("%0t: pad bits expected 0 actual %h", $time, m_tdata[71:68]);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_gap = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("bgr_pixel_pair_format_converter_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [1:0] fmt;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Corner colors under every format code, reserved one included
        for (int f = 0; f < 4; f++) begin
            write_format(2'(f));
            @(negedge aclk);
            for (int i = 0; i < 6; i++)
                queue_pair(corner_pairs[i], i[0]);
            wait_drained();
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            fmt = phase_format[ph];
            write_format(fmt);
            @(negedge aclk);
            steady = (ph % 3 == 2);
            for (int i = 0; i < PAIRS_PER_PHASE; i++)
                queue_pair({pick_level(), pick_level(), pick_level(),
                            pick_level(), pick_level(), pick_level()},
                           $urandom_range(0, 7) == 0);
            wait_drained();
        end

        if (mismatches == 0)
            $display("bgr_pixel_pair_format_converter_tb OK");
        else
            $display("bgr_pixel_pair_format_converter_tb NOT OK");
        $finish;
    end

endmodule
